// ----- sv/cfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the checked frame receiver
// register map, frame check positions and the structs passed between modules
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned ADDR_W = 5;
   localparam int unsigned DATA_W = 32;

   // register indexes (byte address is 4 * index)
   localparam logic [2:0] REG_FIXED_FRAME_ID     = 3'd0;
   localparam logic [2:0] REG_START_MARK_ONE     = 3'd1;
   localparam logic [2:0] REG_START_MARK_TWO     = 3'd2;
   localparam logic [2:0] REG_STOP_MARK_ZERO     = 3'd3;
   localparam logic [2:0] REG_STOP_MARK_ONE      = 3'd4;
   localparam logic [2:0] REG_STOP_MARK_TWO      = 3'd5;
   localparam logic [2:0] REG_FIXED_FRAME_LENGTH = 3'd6;

   localparam logic [BYTE_W-1:0] FIXED_FRAME_LENGTH_RST = 8'd47;

   // frame positions with fixed meaning
   localparam logic [BYTE_W-1:0] POS_ID         = 8'd0;
   localparam logic [BYTE_W-1:0] POS_LENGTH     = 8'd1;
   localparam logic [BYTE_W-1:0] POS_START_TWO  = 8'd2;
   localparam logic [BYTE_W-1:0] STOP_POS_ZERO  = 8'd44;
   localparam logic [BYTE_W-1:0] STOP_POS_ONE   = 8'd45;
   localparam logic [BYTE_W-1:0] STOP_POS_TWO   = 8'd46;
   localparam logic [BYTE_W-1:0] MIN_FRAME_LENGTH = 8'd3;

   localparam logic [BYTE_W-1:0] FRAME_LENGTH_RST = 8'd255;
   localparam logic [BYTE_W-1:0] FRAME_ID_RST     = 8'd255;

   typedef struct packed {
      logic [BYTE_W-1:0] fixed_frame_id;
      logic [BYTE_W-1:0] start_mark_one;
      logic [BYTE_W-1:0] start_mark_two;
      logic [BYTE_W-1:0] stop_mark_zero;
      logic [BYTE_W-1:0] stop_mark_one;
      logic [BYTE_W-1:0] stop_mark_two;
      logic [BYTE_W-1:0] fixed_frame_length;
   } cfr_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] write_position;
      logic [BYTE_W-1:0] frame_length;
      logic [BYTE_W-1:0] frame_id;
   } cfr_state_type;

   typedef struct packed {
      logic              store_valid;
      logic [BYTE_W-1:0] store_index;
      logic [BYTE_W-1:0] store_value;
      logic              rejected;
      logic              frame_done;
      logic              is_fixed_frame;
   } cfr_result_type;

endpackage

// ----- sv/cfr_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_ifs: channel interfaces of the checked frame receiver
// received byte channel and framing result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface cfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       store_valid;
   logic [7:0] store_index;
   logic [7:0] store_value;
   logic       rejected;
   logic       frame_done;
   logic       is_fixed_frame;

   modport source (output valid, output store_valid, output store_index,
                   output store_value, output rejected, output frame_done,
                   output is_fixed_frame, input ready);
   modport sink   (input valid, input store_valid, input store_index,
                   input store_value, input rejected, input frame_done,
                   input is_fixed_frame, output ready);
endinterface

// ----- sv/cfr_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_check: per-byte frame check
// checks one byte against its frame position, gives the result and next state
// ----------------------------------------------------------------------------
module cfr_check #(
   parameter logic [cfr_pkg::BYTE_W-1:0] STOP_POS_ZERO = cfr_pkg::STOP_POS_ZERO,
   parameter logic [cfr_pkg::BYTE_W-1:0] STOP_POS_ONE  = cfr_pkg::STOP_POS_ONE,
   parameter logic [cfr_pkg::BYTE_W-1:0] STOP_POS_TWO  = cfr_pkg::STOP_POS_TWO
) (
   input  logic [7:0]              rx_byte,
   input  cfr_pkg::cfr_cfg_type    cfg,
   input  cfr_pkg::cfr_state_type  state,
   output cfr_pkg::cfr_state_type  state_next,
   output cfr_pkg::cfr_result_type result
);
   import cfr_pkg::*;

   logic [BYTE_W-1:0] pos;
   logic [BYTE_W-1:0] pos_next;
   logic [BYTE_W-1:0] value;
   logic              fixed;
   logic              bad;

   always_comb begin
      // position at or past the stored length starts a new frame
      pos   = (state.write_position >= state.frame_length) ? POS_ID : state.write_position;
      fixed = (state.frame_id == cfg.fixed_frame_id);
      value = rx_byte;
      bad   = 1'b0;
      if (pos == POS_ID) begin
         bad = (rx_byte == '0);
      end else if (pos == POS_LENGTH) begin
         if (rx_byte < MIN_FRAME_LENGTH) begin
            bad = 1'b1;
         end else if (fixed) begin
            bad   = (rx_byte != cfg.start_mark_one);
            value = cfg.fixed_frame_length;
         end
      end else if (pos == POS_START_TWO) begin
         bad = fixed && (rx_byte != cfg.start_mark_two);
      end else if (pos == STOP_POS_ZERO) begin
         bad = fixed && (rx_byte != cfg.stop_mark_zero);
      end else if (pos == STOP_POS_ONE) begin
         bad = fixed && (rx_byte != cfg.stop_mark_one);
      end else if (pos == STOP_POS_TWO) begin
         bad = fixed && (rx_byte != cfg.stop_mark_two);
      end
   end

   assign pos_next = pos + 8'd1;

   always_comb begin
      state_next = state;
      if (bad) begin
         state_next.write_position = '0;
      end else begin
         state_next.write_position = pos_next;
         if (pos == POS_ID) begin
            state_next.frame_id = value;
         end else if (pos == POS_LENGTH) begin
            state_next.frame_length = value;
         end
      end
   end

   always_comb begin
      result.store_valid    = !bad;
      result.store_index    = bad ? '0 : pos;
      result.store_value    = bad ? '0 : value;
      result.rejected       = bad;
      result.frame_done     = !bad && (pos_next == state_next.frame_length);
      result.is_fixed_frame = (state_next.frame_id == cfg.fixed_frame_id);
   end

endmodule

// ----- sv/checked_frame_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_frame_receiver: frames a stream of received serial bytes
// checks each byte against its frame position and reports where it belongs
// ----------------------------------------------------------------------------
//  port group | direction | contents
//  req        | in        | rx_byte, one transfer per received byte
//  rsp        | out       | store_valid/index/value, rejected, frame_done,
//             |           | is_fixed_frame, one transfer per received byte
//  apb        | in/out    | seven 8-bit registers at byte address 4*index
//
//  one byte a cycle sustained while rsp is ready: a byte is held in the
//  input register, the check and the state update happen as it moves into
//  the result register; rsp valid rises once the byte has passed through
//  the input register and then the result register
//  reset (synchronous) clears framing state and loads register reset values
//  a stalled rsp holds the result; the input register takes one more byte,
//  then req ready drops until the result moves on
// ----------------------------------------------------------------------------
module checked_frame_receiver #(
   parameter logic [cfr_pkg::BYTE_W-1:0] STOP_POS_ZERO = cfr_pkg::STOP_POS_ZERO,
   parameter logic [cfr_pkg::BYTE_W-1:0] STOP_POS_ONE  = cfr_pkg::STOP_POS_ONE,
   parameter logic [cfr_pkg::BYTE_W-1:0] STOP_POS_TWO  = cfr_pkg::STOP_POS_TWO
) (
   input  logic                        clock,
   input  logic                        reset,
   cfr_req_if.sink                     req,
   cfr_rsp_if.source                   rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cfr_pkg::ADDR_W-1:0]  paddr,
   input  logic [cfr_pkg::DATA_W-1:0]  pwdata,
   output logic [cfr_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import cfr_pkg::*;

   // configuration registers
   cfr_cfg_type    cfg_ff;
   logic           csr_write;
   logic [2:0]     csr_index;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              advance;

   // framing state and result register
   cfr_state_type  state_ff;
   cfr_state_type  state_in;
   cfr_result_type result_in;
   cfr_result_type rsp_ff;
   logic           rsp_valid_ff;

   // ---------------------------------------------------------------- apb
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fixed_frame_id     <= '0;
         cfg_ff.start_mark_one     <= '0;
         cfg_ff.start_mark_two     <= '0;
         cfg_ff.stop_mark_zero     <= '0;
         cfg_ff.stop_mark_one      <= '0;
         cfg_ff.stop_mark_two      <= '0;
         cfg_ff.fixed_frame_length <= FIXED_FRAME_LENGTH_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_FIXED_FRAME_ID:     cfg_ff.fixed_frame_id     <= pwdata[7:0];
            REG_START_MARK_ONE:     cfg_ff.start_mark_one     <= pwdata[7:0];
            REG_START_MARK_TWO:     cfg_ff.start_mark_two     <= pwdata[7:0];
            REG_STOP_MARK_ZERO:     cfg_ff.stop_mark_zero     <= pwdata[7:0];
            REG_STOP_MARK_ONE:      cfg_ff.stop_mark_one      <= pwdata[7:0];
            REG_STOP_MARK_TWO:      cfg_ff.stop_mark_two      <= pwdata[7:0];
            REG_FIXED_FRAME_LENGTH: cfg_ff.fixed_frame_length <= pwdata[7:0];
            default: begin
               // unmapped address, write dropped
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (csr_index)
         REG_FIXED_FRAME_ID:     prdata[7:0] = cfg_ff.fixed_frame_id;
         REG_START_MARK_ONE:     prdata[7:0] = cfg_ff.start_mark_one;
         REG_START_MARK_TWO:     prdata[7:0] = cfg_ff.start_mark_two;
         REG_STOP_MARK_ZERO:     prdata[7:0] = cfg_ff.stop_mark_zero;
         REG_STOP_MARK_ONE:      prdata[7:0] = cfg_ff.stop_mark_one;
         REG_STOP_MARK_TWO:      prdata[7:0] = cfg_ff.stop_mark_two;
         REG_FIXED_FRAME_LENGTH: prdata[7:0] = cfg_ff.fixed_frame_length;
         default:                prdata      = '0;
      endcase
   end

   // ---------------------------------------------------------------- pipeline
   // the byte moves on whenever the result register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
      end
   end

   cfr_check #(
      .STOP_POS_ZERO (STOP_POS_ZERO),
      .STOP_POS_ONE  (STOP_POS_ONE),
      .STOP_POS_TWO  (STOP_POS_TWO)
   ) u_check (
      .rx_byte    (in_byte_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // framing state only changes as a byte is checked
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.write_position <= '0;
         state_ff.frame_length   <= FRAME_LENGTH_RST;
         state_ff.frame_id       <= FRAME_ID_RST;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.store_valid    = rsp_ff.store_valid;
   assign rsp.store_index    = rsp_ff.store_index;
   assign rsp.store_value    = rsp_ff.store_value;
   assign rsp.rejected       = rsp_ff.rejected;
   assign rsp.frame_done     = rsp_ff.frame_done;
   assign rsp.is_fixed_frame = rsp_ff.is_fixed_frame;

   // ---------------------------------------------------------------- checks
   // a rejected byte restarts framing at position zero
   a_reject_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && result_in.rejected |=> state_ff.write_position == '0)
      else $error("write position not cleared after a rejected byte");

   // a completed frame leaves the position equal to the stored length
   a_done_at_length: assert property (@(posedge clock) disable iff (reset)
      advance && result_in.frame_done |=> state_ff.write_position == state_ff.frame_length)
      else $error("frame done without position reaching length");

   // a held byte is neither lost nor overwritten
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register changed while stalled");

   // a stored byte and a reject never come together
   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.store_valid != rsp_ff.rejected)
                       && !(rsp_ff.rejected && rsp_ff.frame_done))
      else $error("inconsistent result flags");

endmodule

// ----- tb/checked_frame_receiver_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_frame_receiver_test: self-checking bench for the frame receiver
// a short directed walk over ids, lengths, start marks and fixed length, then
// phases of random configuration and register extremes with byte streams
// built from the tracked framing state so that fixed frames reach their stop
// positions; results are checked against typed values or a framing predictor
// ----------------------------------------------------------------------------
module checked_frame_receiver_test;
   import cfr_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int NUM_PHASES      = 10;
   localparam int MAX_REPORTS     = 10;

   // directed rows either carry one received byte or one register write
   typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [2:0]      reg_index;
      logic [7:0]      data;
      logic            known;      // result typed into the row
      cfr_result_type  result;
   } dir_row_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic pready;

   cfr_req_if req_ch ();
   cfr_rsp_if rsp_ch ();

   checked_frame_receiver uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow of the registers and of the framing state, as the block should hold them
   cfr_cfg_type reg_shadow;
   logic [7:0]  track_pos;
   logic [7:0]  track_length;
   logic [7:0]  track_id;

   cfr_result_type due_results[$];
   dir_row_type    directed_rows[$];

   int  mismatch_count   = 0;
   int  cycle_count      = 0;
   bit  tx_idle_on       = 1'b1;
   bit  rx_idle_on       = 1'b1;
   bit  hold_off_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // framing predictor: one received byte in, one result out, state updated
   // ------------------------------------------------------------------------
   function automatic cfr_result_type predict_frame_byte(input logic [7:0] rx);
      cfr_result_type r;
      logic [7:0] pos;
      logic [7:0] value;
      logic       fixed;
      logic       bad;
      value = rx;
      pos   = track_pos;
      fixed = (track_id == reg_shadow.fixed_frame_id);
      bad   = 1'b0;
      // at or past the stored length a new frame starts
      if (pos >= track_length)
         pos = POS_ID;
      if (pos == POS_ID) begin
         bad = (rx == 8'd0);
      end else if (pos == POS_LENGTH) begin
         if (rx < MIN_FRAME_LENGTH)
            bad = 1'b1;
         else if (fixed) begin
            if (rx != reg_shadow.start_mark_one)
               bad = 1'b1;
            else
               value = reg_shadow.fixed_frame_length;
         end
      end else if (pos == POS_START_TWO) begin
         bad = fixed && (rx != reg_shadow.start_mark_two);
      end else if (pos == STOP_POS_ZERO) begin
         // lower stop mark wins should stop positions coincide
         bad = fixed && (rx != reg_shadow.stop_mark_zero);
      end else if (pos == STOP_POS_ONE) begin
         bad = fixed && (rx != reg_shadow.stop_mark_one);
      end else if (pos == STOP_POS_TWO) begin
         bad = fixed && (rx != reg_shadow.stop_mark_two);
      end
      r = '0;
      if (bad) begin
         // frame dropped, id and length kept
         track_pos  = POS_ID;
         r.rejected = 1'b1;
      end else begin
         if (pos == POS_ID)
            track_id = value;
         else if (pos == POS_LENGTH)
            track_length = value;
         track_pos     = pos + 8'd1;
         r.store_valid = 1'b1;
         r.store_index = pos;
         r.store_value = value;
         r.frame_done  = (track_pos == track_length);
      end
      r.is_fixed_frame = (track_id == reg_shadow.fixed_frame_id);
      return r;
   endfunction

   function automatic cfr_result_type framing_result(input logic v, input logic [7:0] idx,
                                                     input logic [7:0] val, input logic rej,
                                                     input logic done, input logic fix);
      cfr_result_type r;
      r.store_valid    = v;
      r.store_index    = idx;
      r.store_value    = val;
      r.rejected       = rej;
      r.frame_done     = done;
      r.is_fixed_frame = fix;
      return r;
   endfunction

   function automatic dir_row_type byte_row(input logic [7:0] rx, input logic known,
                                            input cfr_result_type r);
      dir_row_type row;
      row.kind      = ROW_BYTE;
      row.reg_index = REG_FIXED_FRAME_ID;
      row.data      = rx;
      row.known     = known;
      row.result    = r;
      return row;
   endfunction

   function automatic dir_row_type cfg_row(input logic [2:0] idx, input logic [7:0] val);
      dir_row_type row;
      row.kind      = ROW_CFG;
      row.reg_index = idx;
      row.data      = val;
      row.known     = 1'b0;
      row.result    = '0;
      return row;
   endfunction

   // register value with the odd extreme thrown in
   function automatic logic [7:0] pick_reg_value(input int lo);
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(lo, 255));
      endcase
   endfunction

   // next byte of a mostly well-formed stream, steered by the tracked frame position
   function automatic logic [7:0] next_rx_byte();
      logic [7:0] pos;
      logic       fixed;
      logic [7:0] rx;
      pos   = (track_pos >= track_length) ? POS_ID : track_pos;
      fixed = (track_id == reg_shadow.fixed_frame_id);
      rx    = 8'($urandom_range(0, 255));
      // a few bytes are left as noise so that checks fail now and then
      if ($urandom_range(0, 99) < 8)
         return rx;
      if (pos == POS_ID) begin
         if ($urandom_range(0, 9) < 6 && reg_shadow.fixed_frame_id != 8'd0)
            rx = reg_shadow.fixed_frame_id;
         else
            rx = 8'($urandom_range(1, 255));
      end else if (pos == POS_LENGTH) begin
         if (fixed)
            rx = reg_shadow.start_mark_one;
         else begin
            case ($urandom_range(0, 19))
               0:          rx = 8'd255;
               1, 2, 3, 4: rx = 8'($urandom_range(47, 64));
               default:    rx = 8'($urandom_range(3, 12));
            endcase
         end
      end else if (fixed) begin
         if (pos == POS_START_TWO)
            rx = reg_shadow.start_mark_two;
         else if (pos == STOP_POS_ZERO)
            rx = reg_shadow.stop_mark_zero;
         else if (pos == STOP_POS_ONE)
            rx = reg_shadow.stop_mark_one;
         else if (pos == STOP_POS_TWO)
            rx = reg_shadow.stop_mark_two;
      end
      return rx;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus tasks, each entered just after a rising edge
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] rx, input logic known,
                            input cfr_result_type typed);
      cfr_result_type predicted;
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= rx;
      do
         @(posedge clock);
      while (!req_ch.ready);
      // transfer taken at this edge: the predictor runs in acceptance order
      predicted = predict_frame_byte(rx);
      due_results.push_back(known ? typed : predicted);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // register taken at the edge just passed
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_FIXED_FRAME_ID:     reg_shadow.fixed_frame_id     = val;
         REG_START_MARK_ONE:     reg_shadow.start_mark_one     = val;
         REG_START_MARK_TWO:     reg_shadow.start_mark_two     = val;
         REG_STOP_MARK_ZERO:     reg_shadow.stop_mark_zero     = val;
         REG_STOP_MARK_ONE:      reg_shadow.stop_mark_one      = val;
         REG_STOP_MARK_TWO:      reg_shadow.stop_mark_two      = val;
         REG_FIXED_FRAME_LENGTH: reg_shadow.fixed_frame_length = val;
         default: ;
      endcase
      // the bus idles before the next write
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side: ready with random stalls and one long hold-off
   // ------------------------------------------------------------------------
   initial begin
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            // long stall so the block fills up and pushes back on req
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // result checker, oldest expectation first
   always @(posedge clock) begin
      cfr_result_type got;
      cfr_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.store_valid    = rsp_ch.store_valid;
         got.store_index    = rsp_ch.store_index;
         got.store_value    = rsp_ch.store_value;
         got.rejected       = rsp_ch.rejected;
         got.frame_done     = rsp_ch.frame_done;
         got.is_fixed_frame = rsp_ch.is_fixed_frame;
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result transfer with nothing due: %p", $time, got);
         end else begin
            want = due_results.pop_front();
            if (got.store_valid !== want.store_valid || got.store_index !== want.store_index ||
                got.store_value !== want.store_value || got.rejected !== want.rejected ||
                got.frame_done !== want.frame_done ||
                got.is_fixed_frame !== want.is_fixed_frame) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: wrong result\n   expected %p\n   actual   %p",
                           $time, want, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int         phase;
      int         n_items;
      logic [7:0] v_id, v_m1, v_m2, v_s0, v_s1, v_s2, v_len;

      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= 8'd0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;

      reg_shadow                    = '0;
      reg_shadow.fixed_frame_length = FIXED_FRAME_LENGTH_RST;
      track_pos                     = POS_ID;
      track_length                  = FRAME_LENGTH_RST;
      track_id                      = FRAME_ID_RST;

      // reset state: zero id, lengths below minimum, a three-byte frame
      directed_rows.push_back(byte_row(8'h00, 1'b1,
         framing_result(1'b0, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0)));
      directed_rows.push_back(byte_row(8'hFF, 1'b1,
         framing_result(1'b1, 8'd0, 8'hFF, 1'b0, 1'b0, 1'b0)));
      directed_rows.push_back(byte_row(8'h02, 1'b1,
         framing_result(1'b0, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0)));
      directed_rows.push_back(byte_row(8'h80, 1'b1,
         framing_result(1'b1, 8'd0, 8'h80, 1'b0, 1'b0, 1'b0)));
      directed_rows.push_back(byte_row(8'h03, 1'b1,
         framing_result(1'b1, 8'd1, 8'h03, 1'b0, 1'b0, 1'b0)));
      directed_rows.push_back(byte_row(8'h55, 1'b1,
         framing_result(1'b1, 8'd2, 8'h55, 1'b0, 1'b1, 1'b0)));
      // fixed frame type with its start marks
      directed_rows.push_back(cfg_row(REG_FIXED_FRAME_ID, 8'h0E));
      directed_rows.push_back(cfg_row(REG_START_MARK_ONE, 8'h04));
      directed_rows.push_back(cfg_row(REG_START_MARK_TWO, 8'h0C));
      // wrap to a new frame, wrong start mark, length substitution, wrong second mark
      directed_rows.push_back(byte_row(8'h0E, 1'b1,
         framing_result(1'b1, 8'd0, 8'h0E, 1'b0, 1'b0, 1'b1)));
      directed_rows.push_back(byte_row(8'h05, 1'b1,
         framing_result(1'b0, 8'd0, 8'h00, 1'b1, 1'b0, 1'b1)));
      directed_rows.push_back(byte_row(8'h0E, 1'b1,
         framing_result(1'b1, 8'd0, 8'h0E, 1'b0, 1'b0, 1'b1)));
      directed_rows.push_back(byte_row(8'h04, 1'b1,
         framing_result(1'b1, 8'd1, 8'h2F, 1'b0, 1'b0, 1'b1)));
      directed_rows.push_back(byte_row(8'h0D, 1'b1,
         framing_result(1'b0, 8'd0, 8'h00, 1'b1, 1'b0, 1'b1)));
      // shortest fixed frame that completes
      directed_rows.push_back(cfg_row(REG_FIXED_FRAME_LENGTH, 8'd3));
      directed_rows.push_back(byte_row(8'h0E, 1'b0, '0));
      directed_rows.push_back(byte_row(8'h04, 1'b0, '0));
      directed_rows.push_back(byte_row(8'h0C, 1'b0, '0));
      // zero fixed length never completes, every following byte restarts framing
      directed_rows.push_back(cfg_row(REG_FIXED_FRAME_LENGTH, 8'd0));
      directed_rows.push_back(byte_row(8'h0E, 1'b1,
         framing_result(1'b1, 8'd0, 8'h0E, 1'b0, 1'b0, 1'b1)));
      directed_rows.push_back(byte_row(8'h04, 1'b1,
         framing_result(1'b1, 8'd1, 8'h00, 1'b0, 1'b0, 1'b1)));
      directed_rows.push_back(byte_row(8'h0C, 1'b1,
         framing_result(1'b1, 8'd0, 8'h0C, 1'b0, 1'b0, 1'b0)));
      directed_rows.push_back(byte_row(8'hFF, 1'b1,
         framing_result(1'b1, 8'd0, 8'hFF, 1'b0, 1'b0, 1'b0)));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            wait_idle();
            write_reg(directed_rows[i].reg_index, directed_rows[i].data);
         end else begin
            send_byte(directed_rows[i].data, directed_rows[i].known, directed_rows[i].result);
         end
      end

      // random phases, each with its own register setting
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               // every register at its top value
               v_id = 8'd255; v_m1 = 8'd255; v_m2 = 8'd255;
               v_s0 = 8'd255; v_s1 = 8'd255; v_s2 = 8'd255; v_len = 8'd255;
            end
            1: begin
               // every register at its bottom value
               v_id = 8'd0; v_m1 = 8'd0; v_m2 = 8'd0;
               v_s0 = 8'd0; v_s1 = 8'd0; v_s2 = 8'd0; v_len = 8'd0;
            end
            2: begin
               // plain fixed frames long enough to pass the stop marks
               v_id  = 8'($urandom_range(1, 255));
               v_m1  = 8'($urandom_range(3, 255));
               v_m2  = 8'($urandom_range(0, 255));
               v_s0  = 8'($urandom_range(0, 255));
               v_s1  = 8'($urandom_range(0, 255));
               v_s2  = 8'($urandom_range(0, 255));
               v_len = 8'($urandom_range(47, 64));
            end
            default: begin
               v_id = pick_reg_value(1);
               v_m1 = pick_reg_value(3);
               v_m2 = pick_reg_value(0);
               v_s0 = pick_reg_value(0);
               v_s1 = pick_reg_value(0);
               v_s2 = pick_reg_value(0);
               case ($urandom_range(0, 9))
                  0:       v_len = 8'($urandom_range(0, 3));
                  1:       v_len = 8'd255;
                  2, 3:    v_len = 8'($urandom_range(4, 46));
                  default: v_len = 8'($urandom_range(47, 64));
               endcase
            end
         endcase
         write_reg(REG_FIXED_FRAME_ID, v_id);
         write_reg(REG_START_MARK_ONE, v_m1);
         write_reg(REG_START_MARK_TWO, v_m2);
         write_reg(REG_STOP_MARK_ZERO, v_s0);
         write_reg(REG_STOP_MARK_ONE, v_s1);
         write_reg(REG_STOP_MARK_TWO, v_s2);
         write_reg(REG_FIXED_FRAME_LENGTH, v_len);

         // idling in bursts, one phase free on each side, none in the last phases
         tx_idle_on = (phase < NUM_PHASES - 2) && (phase != 4);
         rx_idle_on = (phase < NUM_PHASES - 2) && (phase != 5);
         if (phase == 3)
            hold_off_request = 1'b1;

         n_items = (phase == 0) ? 300 : 140;
         repeat (n_items)
            send_byte(next_rx_byte(), 1'b0, '0);
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && due_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
